FILE: rtl/bms_serial_request_responder_core_macros.svh
// Assertion macros shared by the responder checker.
`ifndef BMS_SERIAL_REQUEST_RESPONDER_CORE_MACROS_SVH
`define BMS_SERIAL_REQUEST_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define BSRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define BSRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bsrr_pkg.sv
// Types and constants of the battery serial request responder.
package bsrr_pkg;

  localparam logic [7:0] SOF_BYTE   = 8'hDD;
  localparam logic [7:0] CMD_READ   = 8'hA5;
  localparam logic [7:0] PAD_BYTE   = 8'h00;
  localparam logic [7:0] EOF_BYTE   = 8'h77;
  localparam logic [7:0] STATUS_OK  = 8'h00;
  localparam logic [7:0] STATUS_ERR = 8'h80;

  localparam logic [7:0] REG_INFO  = 8'h03;
  localparam logic [7:0] REG_CELLS = 8'h04;
  localparam logic [7:0] REG_NAME  = 8'h05;

  localparam logic [15:0] CK_INFO  = 16'hFFFD;
  localparam logic [15:0] CK_CELLS = 16'hFFFC;
  localparam logic [15:0] CK_NAME  = 16'hFFFB;

  // Whole frame lengths: header (4) + payload + checksum (2) + end byte.
  localparam logic [5:0] LEN_INFO  = 6'd45;
  localparam logic [5:0] LEN_CELLS = 6'd15;
  localparam logic [5:0] LEN_NAME  = 6'd13;
  localparam logic [5:0] LEN_ERROR = 6'd7;
  localparam logic [5:0] LEN_FIXED = 6'd7;

  typedef enum logic [2:0] {
    CFG_PACK_VOLTAGE       = 3'd0,
    CFG_PACK_CURRENT       = 3'd1,
    CFG_REMAINING_CAPACITY = 3'd2,
    CFG_FULL_CAPACITY      = 3'd3,
    CFG_CHARGE_CYCLES      = 3'd4,
    CFG_STATE_OF_CHARGE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FK_INFO  = 2'd0,
    FK_CELLS = 2'd1,
    FK_NAME  = 2'd2,
    FK_ERROR = 2'd3
  } frame_kind_e;

  typedef enum logic [7:0] {
    ST_SOF  = 8'b0000_0001,
    ST_CMD  = 8'b0000_0010,
    ST_REG  = 8'b0000_0100,
    ST_PAD  = 8'b0000_1000,
    ST_CKH  = 8'b0001_0000,
    ST_CKL  = 8'b0010_0000,
    ST_EOF  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

endpackage

FILE: rtl/bms_serial_request_responder_core.sv
// Top level: request frame parser and response frame sequencer.
//
//  channel | direction | words           | handshake
//  --------+-----------+-----------------+----------------------------------
//  rx      | in        | rx_byte_i       | in_valid_i / in_stall_o
//  tx      | out       | tx_byte_o,      | out_valid_o / out_stall_i
//          |           | last_byte_o     |
//  cfg     | in        | cfg_data_i      | cfg_we_i, cfg_index_i, no wait
//
// Request words are taken while rx is not stalled. The end word of a
// well-framed request starts the sequencer, which builds one response word a
// cycle while tx is not stalled (45 for register 3, 15 for 4, 13 for 5, 7 for
// the error frame), the single 16-bit accumulator forming the checksum on the
// fly. The rx side is stalled from the end word until the last response word
// is loaded into the output register. Stalls on tx hold that register and
// freeze the sequencer. Reset clears the parser, the sequencer and the output
// valid, and loads the configuration registers with their defaults.
module bms_serial_request_responder_core import bsrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers
  logic [15:0]        pack_voltage_q;
  logic signed [15:0] pack_current_q;
  logic [15:0]        remaining_capacity_q;
  logic [15:0]        full_capacity_q;
  logic [15:0]        charge_cycles_q;
  logic [6:0]         state_of_charge_q;

  // Parser and sequencer state
  state_e      state_q, state_d;
  logic [7:0]  reg_num_q;
  logic [15:0] rx_ck_q;
  frame_kind_e kind_q, kind_w;
  logic [5:0]  len_q, len_w;
  logic [5:0]  idx_q;
  logic [15:0] sum_q;

  // Output register
  logic        out_valid_q;
  logic [7:0]  tx_q;
  logic        last_q;

  logic        accept;
  logic        load;
  logic        frame_end;
  logic        sum_en;
  logic [5:0]  pay_idx;
  logic [15:0] ck_w;
  logic [7:0]  info_byte, cells_byte, name_byte, pay_byte, byte_w;

  assign in_stall_o  = (state_q == ST_EMIT);
  assign accept      = in_valid_i && !in_stall_o;
  // In the emit state, load a new word whenever the output register is free or being taken.
  assign load        = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign frame_end   = (idx_q == len_q - 6'd1);
  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_q;
  assign last_byte_o = last_q;

  // Classify the request once the whole frame is in.
  always_comb begin
    priority if (reg_num_q == REG_INFO && rx_ck_q == CK_INFO) begin
      kind_w = FK_INFO;
      len_w  = LEN_INFO;
    end else if (reg_num_q == REG_CELLS && rx_ck_q == CK_CELLS) begin
      kind_w = FK_CELLS;
      len_w  = LEN_CELLS;
    end else if (reg_num_q == REG_NAME && rx_ck_q == CK_NAME) begin
      kind_w = FK_NAME;
      len_w  = LEN_NAME;
    end else begin
      kind_w = FK_ERROR;
      len_w  = LEN_ERROR;
    end
  end

  // Parser walk; a nonzero pad word leaves it waiting on the pad.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SOF:  if (accept) state_d = (rx_byte_i == SOF_BYTE) ? ST_CMD : ST_SOF;
      ST_CMD:  if (accept) state_d = (rx_byte_i == CMD_READ) ? ST_REG : ST_SOF;
      ST_REG:  if (accept) state_d = ST_PAD;
      ST_PAD:  if (accept && rx_byte_i == PAD_BYTE) state_d = ST_CKH;
      ST_CKH:  if (accept) state_d = ST_CKL;
      ST_CKL:  if (accept) state_d = ST_EOF;
      ST_EOF:  if (accept) state_d = (rx_byte_i == EOF_BYTE) ? ST_EMIT : ST_SOF;
      ST_EMIT: if (load && frame_end) state_d = ST_SOF;
      default: state_d = ST_SOF;
    endcase
  end

  // Payload position of the word being built.
  assign pay_idx = idx_q - 6'd4;

  // Register 3 payload: live telemetry mixed with fixed template words.
  always_comb begin
    unique case (pay_idx)
      6'd0:    info_byte = pack_voltage_q[15:8];
      6'd1:    info_byte = pack_voltage_q[7:0];
      6'd2:    info_byte = pack_current_q[15:8];
      6'd3:    info_byte = pack_current_q[7:0];
      6'd4:    info_byte = remaining_capacity_q[15:8];
      6'd5:    info_byte = remaining_capacity_q[7:0];
      6'd6:    info_byte = full_capacity_q[15:8];
      6'd7:    info_byte = full_capacity_q[7:0];
      6'd8:    info_byte = charge_cycles_q[15:8];
      6'd9:    info_byte = charge_cycles_q[7:0];
      6'd10:   info_byte = 8'h29;
      6'd11:   info_byte = 8'h98;
      6'd12:   info_byte = 8'h00;
      6'd13:   info_byte = 8'h05;
      6'd14:   info_byte = 8'hF0;
      6'd15:   info_byte = 8'hF0;
      6'd16:   info_byte = 8'hF0;
      6'd17:   info_byte = 8'hF0;
      6'd18:   info_byte = 8'h11;
      6'd19:   info_byte = {1'b0, state_of_charge_q};
      6'd20:   info_byte = 8'h03;
      6'd21:   info_byte = 8'h04;
      6'd22:   info_byte = 8'h03;
      6'd23:   info_byte = 8'h0B;  // 3004
      6'd24:   info_byte = 8'hBC;
      6'd25:   info_byte = 8'h0B;  // 2964
      6'd26:   info_byte = 8'h94;
      6'd27:   info_byte = 8'h0B;  // 2954
      6'd28:   info_byte = 8'h8A;
      6'd29:   info_byte = 8'h37;  // 55
      6'd30:   info_byte = 8'h00;
      6'd31:   info_byte = 8'h00;
      6'd32:   info_byte = full_capacity_q[15:8];
      6'd33:   info_byte = full_capacity_q[7:0];
      6'd34:   info_byte = remaining_capacity_q[15:8];
      6'd35:   info_byte = remaining_capacity_q[7:0];
      6'd36:   info_byte = 8'h02;  // 558 mA balance current
      6'd37:   info_byte = 8'h2E;
      default: info_byte = 8'h00;
    endcase
  end

  // Register 4 payload: four cell voltages in mV.
  always_comb begin
    unique case (pay_idx)
      6'd0:    cells_byte = 8'h0C;
      6'd1:    cells_byte = 8'h33;
      6'd2:    cells_byte = 8'h0C;
      6'd3:    cells_byte = 8'h44;
      6'd4:    cells_byte = 8'h0C;
      6'd5:    cells_byte = 8'h4E;
      6'd6:    cells_byte = 8'h0C;
      6'd7:    cells_byte = 8'h58;
      default: cells_byte = 8'h00;
    endcase
  end

  // Register 5 payload: length-prefixed name string.
  always_comb begin
    unique case (pay_idx)
      6'd0:    name_byte = 8'h05;
      6'd1:    name_byte = 8'h4D;
      6'd2:    name_byte = 8'h59;
      6'd3:    name_byte = 8'h42;
      6'd4:    name_byte = 8'h4D;
      6'd5:    name_byte = 8'h53;
      default: name_byte = 8'h00;
    endcase
  end

  always_comb begin
    unique case (kind_q)
      FK_INFO:  pay_byte = info_byte;
      FK_CELLS: pay_byte = cells_byte;
      FK_NAME:  pay_byte = name_byte;
      FK_ERROR: pay_byte = 8'h00;
      default:  pay_byte = 8'h00;
    endcase
  end

  // Checksum is the two's complement of the accumulated sum; by the time the
  // first checksum word is built, every summed word has gone through.
  assign ck_w = 16'h0000 - sum_q;

  // Frame assembly: header, payload, checksum, end word.
  always_comb begin
    priority if (idx_q == 6'd0) begin
      byte_w = SOF_BYTE;
    end else if (idx_q == 6'd1) begin
      byte_w = reg_num_q;
    end else if (idx_q == 6'd2) begin
      byte_w = (kind_q == FK_ERROR) ? STATUS_ERR : STATUS_OK;
    end else if (idx_q == 6'd3) begin
      byte_w = {2'b00, len_q - LEN_FIXED};
    end else if (frame_end) begin
      byte_w = EOF_BYTE;
    end else if (idx_q == len_q - 6'd2) begin
      byte_w = ck_w[7:0];
    end else if (idx_q == len_q - 6'd3) begin
      byte_w = ck_w[15:8];
    end else begin
      byte_w = pay_byte;
    end
  end

  // Sum covers the status word through the end of the payload.
  assign sum_en = (idx_q >= 6'd2) && (idx_q < len_q - 6'd3);

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_voltage_q       <= 16'd1240;
      pack_current_q       <= 16'sd450;
      remaining_capacity_q <= 16'd28000;
      full_capacity_q      <= 16'd30400;
      charge_cycles_q      <= 16'd386;
      state_of_charge_q    <= 7'd89;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PACK_VOLTAGE:       pack_voltage_q       <= cfg_data_i;
        CFG_PACK_CURRENT:       pack_current_q       <= cfg_data_i;
        CFG_REMAINING_CAPACITY: remaining_capacity_q <= cfg_data_i;
        CFG_FULL_CAPACITY:      full_capacity_q      <= cfg_data_i;
        CFG_CHARGE_CYCLES:      charge_cycles_q      <= cfg_data_i;
        CFG_STATE_OF_CHARGE:    state_of_charge_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SOF;
      idx_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EOF && accept) begin
        idx_q <= 6'd0;
      end else if (load) begin
        idx_q <= idx_q + 6'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_REG && accept) begin
      reg_num_q <= rx_byte_i;
    end
    if (state_q == ST_CKH && accept) begin
      rx_ck_q[15:8] <= rx_byte_i;
    end
    if (state_q == ST_CKL && accept) begin
      rx_ck_q[7:0] <= rx_byte_i;
    end
    if (state_q == ST_EOF && accept) begin
      kind_q <= kind_w;
      len_q  <= len_w;
      sum_q  <= 16'h0000;
    end else if (load && sum_en) begin
      sum_q <= sum_q + {8'h00, byte_w};
    end
    if (load) begin
      tx_q   <= byte_w;
      last_q <= frame_end;
    end
  end

endmodule

FILE: rtl/bsrr_checker.sv
// Port-level checker for the responder, bound to the top level.
`include "bms_serial_request_responder_core_macros.svh"

module bsrr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] tx_byte_o,
  input logic       last_byte_o
);

  `BSRR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(tx_byte_o) && $stable(last_byte_o), "stalled output word changed")

  `BSRR_ASSERT_NOW(a_rx_held_mid_frame, out_valid_o && !last_byte_o, in_stall_o, "rx taken while a response is in flight")

  `BSRR_ASSERT_NEXT(a_no_gap, out_valid_o && !out_stall_i && !last_byte_o, out_valid_o, "gap inside a response frame")

  `BSRR_ASSERT_NOW(a_frame_start, $rose(out_valid_o), tx_byte_o == 8'hDD && !last_byte_o, "response frame does not open with the start word")

endmodule

bind bms_serial_request_responder_core bsrr_checker u_bsrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .tx_byte_o   (tx_byte_o),
  .last_byte_o (last_byte_o)
);
